// ----- rtl/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define CDA_ASSERT_NOW(name, clk, rst_n, lhs, rhs) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("calendar date adder check failed");

// implication into the following cycle
`define CDA_ASSERT_NEXT(name, clk, rst_n, lhs, rhs) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("calendar date adder check failed");

`endif

// ----- rtl/cda_pkg.sv -----
package cda_pkg;

    // request opcodes
    localparam logic [1:0] OPC_LOAD   = 2'd0;
    localparam logic [1:0] OPC_YEARS  = 2'd1;
    localparam logic [1:0] OPC_MONTHS = 2'd2;
    localparam logic [1:0] OPC_DAYS   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_DEFAULT_YEAR  = 2'd0;
    localparam logic [1:0] REG_DEFAULT_MONTH = 2'd1;
    localparam logic [1:0] REG_DEFAULT_DAY   = 2'd2;

    localparam int YEAR_MAX = 9999;

    // multiplicative inverse of 25 modulo 2^14, and the divisibility bound
    localparam int INV25       = 7209;
    localparam int INV25_LIMIT = 655;

    // ceil(2^19 / 12), exact for every month total that can occur
    localparam int RECIP12 = 43691;

    localparam int PC_W = 4;

    // entry points and branch targets of the microprogram
    localparam logic [PC_W-1:0] PC_LOAD   = 4'd0;
    localparam logic [PC_W-1:0] PC_YEARS  = 4'd3;
    localparam logic [PC_W-1:0] PC_MONTHS = 4'd6;
    localparam logic [PC_W-1:0] PC_DAYS   = 4'd11;
    localparam logic [PC_W-1:0] PC_DLEAP  = 4'd12;
    localparam logic [PC_W-1:0] PC_DSTEP  = 4'd13;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LSEL,
        OP_LEAP_LD,
        OP_LCHK,
        OP_YADD,
        OP_LEAP_CUR,
        OP_FEB29,
        OP_MTOT,
        OP_MDIV,
        OP_MAPPLY,
        OP_CLAMP,
        OP_DINIT,
        OP_DSTEP
    } op_t;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_STAY,
        COND_WRAPPED
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
        logic            last;
    } ucode_t;

    // datapath conditions seen by the sequencer
    typedef struct packed {
        logic stay;
        logic wrapped;
        logic out_blocked;
    } seq_flags_t;

    // sequencer controls to the datapath
    typedef struct packed {
        logic busy;
        logic exec;
        logic finish;
        op_t  op;
    } seq_ctl_t;

    typedef struct packed {
        logic               ovf;
        logic signed [14:0] year;
    } yp_t;

    function automatic ucode_t uc(input op_t op, input cond_t cond,
                                  input logic [PC_W-1:0] target, input logic last);
        ucode_t w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        w.last   = last;
        return w;
    endfunction

    // control store
    function automatic ucode_t cda_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        unique case (pc)
            4'd0:    w = uc(OP_LSEL,     COND_NONE,    PC_LOAD,  1'b0);
            4'd1:    w = uc(OP_LEAP_LD,  COND_NONE,    PC_LOAD,  1'b0);
            4'd2:    w = uc(OP_LCHK,     COND_NONE,    PC_LOAD,  1'b1);
            4'd3:    w = uc(OP_YADD,     COND_NONE,    PC_LOAD,  1'b0);
            4'd4:    w = uc(OP_LEAP_CUR, COND_NONE,    PC_LOAD,  1'b0);
            4'd5:    w = uc(OP_FEB29,    COND_NONE,    PC_LOAD,  1'b1);
            4'd6:    w = uc(OP_MTOT,     COND_NONE,    PC_LOAD,  1'b0);
            4'd7:    w = uc(OP_MDIV,     COND_NONE,    PC_LOAD,  1'b0);
            4'd8:    w = uc(OP_MAPPLY,   COND_NONE,    PC_LOAD,  1'b0);
            4'd9:    w = uc(OP_LEAP_CUR, COND_NONE,    PC_LOAD,  1'b0);
            4'd10:   w = uc(OP_CLAMP,    COND_NONE,    PC_LOAD,  1'b1);
            4'd11:   w = uc(OP_DINIT,    COND_NONE,    PC_LOAD,  1'b0);
            4'd12:   w = uc(OP_LEAP_CUR, COND_NONE,    PC_LOAD,  1'b0);
            4'd13:   w = uc(OP_DSTEP,    COND_STAY,    PC_DSTEP, 1'b0);
            4'd14:   w = uc(OP_NOP,      COND_WRAPPED, PC_DLEAP, 1'b1);
            default: w = uc(OP_NOP,      COND_NONE,    PC_LOAD,  1'b1);
        endcase
        return w;
    endfunction

    function automatic logic [PC_W-1:0] cda_entry(input logic [1:0] opcode);
        logic [PC_W-1:0] pc;
        unique case (opcode)
            OPC_LOAD:   pc = PC_LOAD;
            OPC_YEARS:  pc = PC_YEARS;
            OPC_MONTHS: pc = PC_MONTHS;
            default:    pc = PC_DAYS;
        endcase
        return pc;
    endfunction

    // leap test on the magnitude: by 4 and not by 100, or by 400
    function automatic logic is_leap(input logic signed [14:0] y);
        logic [14:0] mag;
        logic [26:0] prod;
        logic        div4;
        logic        div16;
        logic        div25;
        mag   = y[14] ? 15'(-y) : 15'(y);
        prod  = {13'b0, mag[13:0]} * 27'(INV25);
        div4  = (mag[1:0] == 2'b00);
        div16 = (mag[3:0] == 4'b0000);
        div25 = (prod[13:0] <= 14'(INV25_LIMIT));
        return div4 && (!div25 || div16);
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd2:                     len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
            default:                  len = 5'd31;
        endcase
        return len;
    endfunction

    // year plus n, skipping year zero, saturating at the top year
    function automatic yp_t year_plus(input logic signed [14:0] y, input logic [16:0] n);
        logic signed [17:0] t;
        yp_t                r;
        t = $signed({{3{y[14]}}, y}) + $signed({1'b0, n});
        if (y[14] && !t[17]) begin
            t = t + 18'sd1;
        end
        if (t > 18'(YEAR_MAX)) begin
            r.year = 15'(YEAR_MAX);
            r.ovf  = 1'b1;
        end else begin
            r.year = t[14:0];
            r.ovf  = 1'b0;
        end
        return r;
    endfunction

endpackage

// ----- rtl/cda_seq.sv -----
module cda_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [1:0]            start_opcode,
    input  cda_pkg::seq_flags_t   flags,
    output cda_pkg::seq_ctl_t     ctl
);
    import cda_pkg::*;

    logic [PC_W-1:0] pc_reg, pc_next;
    logic            busy_reg, busy_next;
    ucode_t          word;
    logic            take;
    logic            retire;
    logic            stall;

    assign word = cda_rom(pc_reg);

    always_comb begin
        unique case (word.cond)
            COND_STAY:    take = flags.stay;
            COND_WRAPPED: take = flags.wrapped;
            default:      take = 1'b0;
        endcase
    end

    assign retire = busy_reg && word.last && !take;
    // the last step waits while the previous result is still unclaimed
    assign stall  = retire && flags.out_blocked;

    assign ctl.busy   = busy_reg;
    assign ctl.exec   = busy_reg && !stall;
    assign ctl.finish = retire && !flags.out_blocked;
    assign ctl.op     = word.op;

    always_comb begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (start) begin
            pc_next   = cda_entry(start_opcode);
            busy_next = 1'b1;
        end else if (busy_reg && !stall) begin
            if (take) begin
                pc_next = word.target;
            end else if (retire) begin
                busy_next = 1'b0;
            end else begin
                pc_next = pc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg   <= PC_LOAD;
            busy_reg <= 1'b0;
        end else begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

endmodule

// ----- rtl/calendar_date_adder_core.sv -----
// Gregorian date adder. Holds one date and takes one request at a time on the
// s_ channel (valid/ready): load a date, or add years, months or days. Each
// request returns exactly one result on the m_ channel: the stored date after
// the step with the date_rejected and year_overflow flags.
// Defaults for zero load fields sit in three APB registers (0x0 year, 0x4
// month, 0x8 day); write them only while no request is in flight.
// A load runs the steps LSEL, LEAP_LD, LCHK; a year add YADD, LEAP_CUR, FEB29;
// a month add MTOT, MDIV, MAPPLY, LEAP_CUR, CLAMP; a day add DINIT, LEAP_CUR,
// then DSTEP once per month carried through the shared month-length step, back
// through LEAP_CUR at each year boundary, and a final NOP before the result.
// s_ready is high whenever no request is being worked on; a finished result
// waits in the m_ output register and the next request can be taken meanwhile,
// from the same cycle in which the result appears.
// If the receiver stalls, the following request runs up to its final step and
// holds there until the waiting result is taken.
// After aresetn the date is 1970-01-01, the defaults are 1970/1/1 and no
// result is pending.
module calendar_date_adder_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic signed [14:0] s_load_year,
    input  logic [3:0]         s_load_month,
    input  logic [4:0]         s_load_day,
    input  logic [15:0]        s_amount,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [14:0] m_year,
    output logic [3:0]         m_month,
    output logic [4:0]         m_day,
    output logic               m_date_rejected,
    output logic               m_year_overflow
);
    import cda_pkg::*;

    seq_ctl_t   ctl;
    seq_flags_t flags;
    logic       accept;
    logic       cfg_wr;

    logic signed [14:0] dflt_year_reg;
    logic [3:0]         dflt_month_reg;
    logic [4:0]         dflt_day_reg;

    logic signed [14:0] yr_reg, yr_next;
    logic [3:0]         mon_reg, mon_next;
    logic [4:0]         day_reg, day_next;
    logic signed [14:0] ly_reg, ly_next;
    logic [3:0]         lm_reg, lm_next;
    logic [4:0]         ld_reg, ld_next;
    logic [15:0]        amt_reg, amt_next;
    logic [16:0]        acc_reg, acc_next;
    logic [12:0]        q_reg, q_next;
    logic               leap_reg, leap_next;
    logic               wrap_reg, wrap_next;
    logic               bad_reg, bad_next;
    logic               ovf_reg, ovf_next;

    logic               m_valid_reg, m_valid_next;
    logic signed [14:0] m_year_reg;
    logic [3:0]         m_month_reg;
    logic [4:0]         m_day_reg;
    logic               m_bad_reg;
    logic               m_ovf_reg;

    logic [4:0]         len;
    logic               fit;
    logic [16:0]        yp_n;
    yp_t                yp;
    logic [32:0]        prod;
    logic [16:0]        rem;
    logic               ld_valid;

    assign accept = s_valid && s_ready;
    assign s_ready = !ctl.busy;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            REG_DEFAULT_YEAR:  prdata = {{17{dflt_year_reg[14]}}, dflt_year_reg};
            REG_DEFAULT_MONTH: prdata = {28'b0, dflt_month_reg};
            REG_DEFAULT_DAY:   prdata = {27'b0, dflt_day_reg};
            default:           prdata = 32'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dflt_year_reg  <= 15'sd1970;
            dflt_month_reg <= 4'd1;
            dflt_day_reg   <= 5'd1;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_DEFAULT_YEAR:  dflt_year_reg  <= pwdata[14:0];
                REG_DEFAULT_MONTH: dflt_month_reg <= pwdata[3:0];
                REG_DEFAULT_DAY:   dflt_day_reg   <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    cda_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (accept),
        .start_opcode (s_opcode),
        .flags        (flags),
        .ctl          (ctl)
    );

    assign len  = days_in(mon_reg, leap_reg);
    assign fit  = (acc_reg <= {12'b0, len});
    assign prod = {16'b0, acc_reg} * 33'(RECIP12);
    assign rem  = acc_reg - ({1'b0, q_reg, 3'b0} + {2'b0, q_reg, 2'b0});

    assign ld_valid = (ly_reg != 15'sd0) && (ly_reg <= 15'sd9999) && (ly_reg >= -15'sd9999)
                   && (lm_reg >= 4'd1) && (lm_reg <= 4'd12)
                   && (ld_reg >= 5'd1) && (ld_reg <= days_in(lm_reg, leap_reg));

    // one shared year adder: amount, whole years of a month add, or a single carry
    always_comb begin
        unique case (ctl.op)
            OP_YADD:   yp_n = {1'b0, amt_reg};
            OP_MAPPLY: yp_n = {4'b0, q_reg};
            default:   yp_n = 17'd1;
        endcase
    end
    assign yp = year_plus(yr_reg, yp_n);

    assign flags.stay        = !fit && (mon_reg != 4'd12);
    assign flags.wrapped     = wrap_reg;
    assign flags.out_blocked = m_valid_reg && !m_ready;

    always_comb begin
        yr_next   = yr_reg;
        mon_next  = mon_reg;
        day_next  = day_reg;
        ly_next   = ly_reg;
        lm_next   = lm_reg;
        ld_next   = ld_reg;
        amt_next  = amt_reg;
        acc_next  = acc_reg;
        q_next    = q_reg;
        leap_next = leap_reg;
        wrap_next = wrap_reg;
        bad_next  = bad_reg;
        ovf_next  = ovf_reg;
        if (accept) begin
            ly_next  = s_load_year;
            lm_next  = s_load_month;
            ld_next  = s_load_day;
            amt_next = s_amount;
            bad_next = 1'b0;
            ovf_next = 1'b0;
        end else if (ctl.exec) begin
            unique case (ctl.op)
                OP_LSEL: begin
                    if (ly_reg == 15'sd0) ly_next = dflt_year_reg;
                    if (lm_reg == 4'd0)   lm_next = dflt_month_reg;
                    if (ld_reg == 5'd0)   ld_next = dflt_day_reg;
                end
                OP_LEAP_LD: begin
                    leap_next = is_leap(ly_reg);
                end
                OP_LCHK: begin
                    if (ld_valid) begin
                        yr_next  = ly_reg;
                        mon_next = lm_reg;
                        day_next = ld_reg;
                    end else begin
                        bad_next = 1'b1;
                    end
                end
                OP_YADD: begin
                    yr_next  = yp.year;
                    ovf_next = ovf_reg | yp.ovf;
                end
                OP_LEAP_CUR: begin
                    leap_next = is_leap(yr_reg);
                end
                OP_FEB29: begin
                    if (mon_reg == 4'd2 && day_reg == 5'd29 && !leap_reg) begin
                        mon_next = 4'd3;
                        day_next = 5'd1;
                    end
                end
                OP_MTOT: begin
                    acc_next = {13'b0, mon_reg - 4'd1} + {1'b0, amt_reg};
                end
                OP_MDIV: begin
                    q_next = prod[31:19];
                end
                OP_MAPPLY: begin
                    mon_next = rem[3:0] + 4'd1;
                    yr_next  = yp.year;
                    ovf_next = ovf_reg | yp.ovf;
                end
                OP_CLAMP: begin
                    if (day_reg > len) day_next = len;
                end
                OP_DINIT: begin
                    acc_next = {12'b0, day_reg} + {1'b0, amt_reg};
                end
                OP_DSTEP: begin
                    if (fit) begin
                        day_next  = acc_reg[4:0];
                        wrap_next = 1'b0;
                    end else begin
                        acc_next = acc_reg - {12'b0, len};
                        if (mon_reg == 4'd12) begin
                            // year boundary: leap flag is refreshed before the next month
                            mon_next  = 4'd1;
                            yr_next   = yp.year;
                            ovf_next  = ovf_reg | yp.ovf;
                            wrap_next = 1'b1;
                        end else begin
                            mon_next  = mon_reg + 4'd1;
                            wrap_next = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yr_reg   <= 15'sd1970;
            mon_reg  <= 4'd1;
            day_reg  <= 5'd1;
            wrap_reg <= 1'b0;
        end else begin
            yr_reg   <= yr_next;
            mon_reg  <= mon_next;
            day_reg  <= day_next;
            wrap_reg <= wrap_next;
        end
    end

    always_ff @(posedge aclk) begin
        ly_reg   <= ly_next;
        lm_reg   <= lm_next;
        ld_reg   <= ld_next;
        amt_reg  <= amt_next;
        acc_reg  <= acc_next;
        q_reg    <= q_next;
        leap_reg <= leap_next;
        bad_reg  <= bad_next;
        ovf_reg  <= ovf_next;
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctl.finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.finish) begin
            m_year_reg  <= yr_next;
            m_month_reg <= mon_next;
            m_day_reg   <= day_next;
            m_bad_reg   <= bad_next;
            m_ovf_reg   <= ovf_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_year          = m_year_reg;
    assign m_month         = m_month_reg;
    assign m_day           = m_day_reg;
    assign m_date_rejected = m_bad_reg;
    assign m_year_overflow = m_ovf_reg;

endmodule

// ----- rtl/cda_checker.sv -----
`include "assert_macros.svh"

module cda_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [14:0] m_year,
    input logic [3:0]         m_month,
    input logic               m_date_rejected,
    input logic               m_year_overflow
);

    // one request at a time: taking a request drops ready
    `CDA_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready)

    // a result that is not taken stays offered
    `CDA_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid)

    `CDA_ASSERT_NOW(a_month_range, aclk, aresetn, m_valid,
                    m_month >= 4'd1 && m_month <= 4'd12 && m_year != 15'sd0)

    // saturation always lands on the top year
    `CDA_ASSERT_NOW(a_ovf_year, aclk, aresetn, m_valid && m_year_overflow,
                    m_year == 15'sd9999)

    // a rejected load never reports a year overflow
    `CDA_ASSERT_NOW(a_bad_no_ovf, aclk, aresetn, m_valid && m_date_rejected, !m_year_overflow)

endmodule

bind calendar_date_adder_core cda_checker u_cda_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_year          (m_year),
    .m_month         (m_month),
    .m_date_rejected (m_date_rejected),
    .m_year_overflow (m_year_overflow)
);

// ----- test/calendar_date_adder_core_test.sv -----
module calendar_date_adder_core_test;

    import cda_pkg::*;

    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic [1:0]         opcode;
        logic signed [14:0] load_year;
        logic [3:0]         load_month;
        logic [4:0]         load_day;
        logic [15:0]        amount;
    } date_req_t;

    typedef struct {
        logic signed [14:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic               date_rejected;
        logic               year_overflow;
    } date_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_opcode = OPC_LOAD;
    logic signed [14:0] s_load_year = '0;
    logic [3:0]         s_load_month = '0;
    logic [4:0]         s_load_day = '0;
    logic [15:0]        s_amount = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [14:0] m_year;
    logic [3:0]         m_month;
    logic [4:0]         m_day;
    logic               m_date_rejected;
    logic               m_year_overflow;

    calendar_date_adder_core u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_load_year     (s_load_year),
        .s_load_month    (s_load_month),
        .s_load_day      (s_load_day),
        .s_amount        (s_amount),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_year          (m_year),
        .m_month         (m_month),
        .m_day           (m_day),
        .m_date_rejected (m_date_rejected),
        .m_year_overflow (m_year_overflow)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    date_req_t    requests_to_send[$];
    date_result_t expected_dates[$];
    date_req_t    on_bus;

    // stored date and default registers as the block should hold them
    int cal_year  = 1970;
    int cal_month = 1;
    int cal_day   = 1;
    int cfg_year  = 1970;
    int cfg_month = 1;
    int cfg_day   = 1;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int checked_count  = 0;
    int rejected_count = 0;
    int saturated_count = 0;
    int op_count[4]    = '{0, 0, 0, 0};
    int cycle_count    = 0;

    function automatic bit leap_year(input int y);
        int a;
        a = (y < 0) ? -y : y;
        return ((a % 4 == 0) && (a % 100 != 0)) || (a % 400 == 0);
    endfunction

    function automatic int month_length(input int y, input int m);
        case (m)
            2:             return leap_year(y) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // no year zero: going up from a negative year skips it
    function automatic int step_year(input int y, input int n, inout bit ovf);
        int t;
        t = y + n;
        if (y < 0 && t >= 0) begin
            t++;
        end
        if (t > YEAR_MAX) begin
            t   = YEAR_MAX;
            ovf = 1'b1;
        end
        return t;
    endfunction

    function automatic date_result_t apply_request(input date_req_t r);
        date_result_t res;
        int y, m, d, len, total;
        bit ovf, bad;
        ovf = 1'b0;
        bad = 1'b0;
        case (r.opcode)
            OPC_LOAD: begin
                y = (r.load_year == 0) ? cfg_year : int'(r.load_year);
                m = (r.load_month == 0) ? cfg_month : int'(r.load_month);
                d = (r.load_day == 0) ? cfg_day : int'(r.load_day);
                if (y == 0 || y > YEAR_MAX || y < -YEAR_MAX || m < 1 || m > 12 ||
                    d < 1 || d > month_length(y, m)) begin
                    bad = 1'b1;
                end else begin
                    cal_year  = y;
                    cal_month = m;
                    cal_day   = d;
                end
            end
            OPC_YEARS: begin
                cal_year = step_year(cal_year, int'(r.amount), ovf);
                if (cal_month == 2 && cal_day == 29 && !leap_year(cal_year)) begin
                    cal_month = 3;
                    cal_day   = 1;
                end
            end
            OPC_MONTHS: begin
                total     = cal_month - 1 + int'(r.amount);
                cal_year  = step_year(cal_year, total / 12, ovf);
                cal_month = total % 12 + 1;
                len       = month_length(cal_year, cal_month);
                if (cal_day > len) begin
                    cal_day = len;
                end
            end
            default: begin
                // carry whole months one at a time, no clamping
                d   = cal_day + int'(r.amount);
                len = month_length(cal_year, cal_month);
                while (d > len) begin
                    d -= len;
                    if (cal_month >= 12) begin
                        cal_month = 1;
                        cal_year  = step_year(cal_year, 1, ovf);
                    end else begin
                        cal_month++;
                    end
                    len = month_length(cal_year, cal_month);
                end
                cal_day = d;
            end
        endcase
        res.year          = 15'(cal_year);
        res.month         = 4'(cal_month);
        res.day           = 5'(cal_day);
        res.date_rejected = bad;
        res.year_overflow = ovf;
        return res;
    endfunction

    function automatic date_req_t random_request();
        date_req_t r;
        int sel, y, m, len;
        sel          = $urandom_range(99);
        r.opcode     = OPC_LOAD;
        r.amount     = 16'($urandom_range(65535));
        r.load_year  = 15'(int'($urandom_range(19998)) - 9999);
        r.load_month = 4'($urandom_range(15));
        r.load_day   = 5'($urandom_range(31));
        if (sel < 30) begin
            sel = $urandom_range(99);
            if (sel < 10) begin
                r.load_year = '0;
            end else if (sel < 25) begin
                r.load_year = 15'(9990 + int'($urandom_range(9)));
            end else if (sel < 35) begin
                r.load_year = 15'(-9999 + int'($urandom_range(9)));
            end else if (sel < 45) begin
                r.load_year = 15'(int'($urandom_range(6)) - 3);
            end else if (sel < 55) begin
                case ($urandom_range(7))
                    0:       r.load_year = 15'(2000);
                    1:       r.load_year = 15'(1900);
                    2:       r.load_year = 15'(2024);
                    3:       r.load_year = -15'sd400;
                    4:       r.load_year = -15'sd100;
                    5:       r.load_year = -15'sd4;
                    6:       r.load_year = 15'(400);
                    default: r.load_year = 15'(100);
                endcase
            end
            sel = $urandom_range(99);
            if (sel < 80) begin
                r.load_month = 4'($urandom_range(12, 1));
            end else if (sel < 90) begin
                r.load_month = '0;
            end else begin
                r.load_month = 4'($urandom_range(15, 13));
            end
            // aim the day at the month that the load will actually see
            y   = (r.load_year == 0) ? cfg_year : int'(r.load_year);
            m   = (r.load_month == 0) ? cfg_month : int'(r.load_month);
            len = month_length(y, m);
            sel = $urandom_range(99);
            if (sel < 65) begin
                r.load_day = 5'($urandom_range(len, 1));
            end else if (sel < 75) begin
                r.load_day = '0;
            end else if (sel < 88) begin
                r.load_day = 5'(len);
            end else begin
                r.load_day = 5'($urandom_range(31, 1));
            end
        end else if (sel < 50) begin
            r.opcode = OPC_YEARS;
            sel      = $urandom_range(99);
            r.amount = (sel < 60) ? 16'($urandom_range(20)) :
                       (sel < 85) ? 16'($urandom_range(500)) : 16'($urandom_range(65535));
        end else if (sel < 70) begin
            r.opcode = OPC_MONTHS;
            sel      = $urandom_range(99);
            r.amount = (sel < 60) ? 16'($urandom_range(24)) :
                       (sel < 85) ? 16'($urandom_range(2000)) : 16'($urandom_range(65535));
        end else begin
            r.opcode = OPC_DAYS;
            sel      = $urandom_range(99);
            // long day walks are slow, so only a few of them
            r.amount = (sel < 55) ? 16'($urandom_range(62)) :
                       (sel < 85) ? 16'($urandom_range(1500, 63)) :
                       (sel < 97) ? 16'($urandom_range(8000, 1500)) :
                       16'($urandom_range(65535));
        end
        return r;
    endfunction

    task automatic push_req(input logic [1:0] op, input int y, input int m, input int d,
                            input int amt);
        date_req_t r;
        r.opcode     = op;
        r.load_year  = 15'(y);
        r.load_month = 4'(m);
        r.load_day   = 5'(d);
        r.amount     = 16'(amt);
        requests_to_send.push_back(r);
    endtask

    task automatic write_default(input logic [1:0] idx, input int val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(val);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DEFAULT_YEAR:  cfg_year  = val;
            REG_DEFAULT_MONTH: cfg_month = val;
            default:           cfg_day   = val;
        endcase
    endtask

    // sender holds off until every request has come back, then a short settle
    task automatic wait_idle();
        @(negedge aclk);
        while (requests_to_send.size() != 0 || s_valid || expected_dates.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic run_random(input int idle_pct, input int stall_pct, input int n);
        @(negedge aclk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n) requests_to_send.push_back(random_request());
        wait_idle();
    endtask

    always @(posedge aclk) begin : drive_requests
        logic next_valid;
        next_valid = s_valid;
        if (!aresetn) begin
            next_valid = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_dates.push_back(apply_request(on_bus));
                op_count[on_bus.opcode]++;
                next_valid = 1'b0;
            end
            if (!next_valid && requests_to_send.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                on_bus       = requests_to_send.pop_front();
                s_opcode     <= on_bus.opcode;
                s_load_year  <= on_bus.load_year;
                s_load_month <= on_bus.load_month;
                s_load_day   <= on_bus.load_day;
                s_amount     <= on_bus.amount;
                next_valid   = 1'b1;
            end
        end
        s_valid <= next_valid;
    end

    always @(posedge aclk) begin : check_results
        date_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_dates.size() == 0) begin
                $error("result with no request outstanding: %0d-%0d-%0d",
                       m_year, m_month, m_day);
                fail_count++;
            end else begin
                want = expected_dates.pop_front();
                checked_count++;
                rejected_count  += want.date_rejected;
                saturated_count += want.year_overflow;
                if (m_year !== want.year) begin
                    $error("year: expected %0d, got %0d", want.year, m_year);
                    fail_count++;
                end
                if (m_month !== want.month) begin
                    $error("month: expected %0d, got %0d", want.month, m_month);
                    fail_count++;
                end
                if (m_day !== want.day) begin
                    $error("day: expected %0d, got %0d", want.day, m_day);
                    fail_count++;
                end
                if (m_date_rejected !== want.date_rejected) begin
                    $error("date_rejected: expected %0b, got %0b",
                           want.date_rejected, m_date_rejected);
                    fail_count++;
                end
                if (m_year_overflow !== want.year_overflow) begin
                    $error("year_overflow: expected %0b, got %0b",
                           want.year_overflow, m_year_overflow);
                    fail_count++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // corners under the reset defaults of 1970-01-01
        @(negedge aclk);
        push_req(OPC_LOAD, 2024, 2, 29, 0);
        push_req(OPC_YEARS, 0, 0, 0, 1);          // feb 29 into a common year
        push_req(OPC_LOAD, 2000, 2, 29, 0);       // divisible by 400
        push_req(OPC_LOAD, 1900, 2, 29, 0);       // divisible by 100 only
        push_req(OPC_LOAD, 0, 0, 0, 0);           // all fields from defaults
        push_req(OPC_LOAD, 2023, 4, 31, 0);
        push_req(OPC_LOAD, 2023, 15, 31, 0);
        push_req(OPC_LOAD, -1, 12, 31, 0);
        push_req(OPC_DAYS, 0, 0, 0, 1);           // -1 rolls straight to 1
        push_req(OPC_LOAD, -1, 6, 15, 0);
        push_req(OPC_YEARS, 0, 0, 0, 1);
        push_req(OPC_LOAD, -4, 2, 29, 0);
        push_req(OPC_LOAD, -100, 2, 29, 0);
        push_req(OPC_LOAD, -400, 2, 29, 0);
        push_req(OPC_MONTHS, 0, 0, 0, 0);
        push_req(OPC_DAYS, 0, 0, 0, 0);
        push_req(OPC_YEARS, 0, 0, 0, 0);
        push_req(OPC_LOAD, 2024, 1, 31, 0);
        push_req(OPC_MONTHS, 0, 0, 0, 1);         // day clamped to feb 29
        push_req(OPC_LOAD, -9999, 1, 1, 0);
        push_req(OPC_MONTHS, 0, 0, 0, 65535);
        push_req(OPC_LOAD, 9999, 12, 31, 0);
        push_req(OPC_DAYS, 0, 0, 0, 1);           // saturates, month wraps in 9999
        push_req(OPC_YEARS, 0, 0, 0, 65535);
        push_req(OPC_LOAD, 1, 1, 1, 0);
        push_req(OPC_DAYS, 0, 0, 0, 65535);
        run_random(0, 0, 30);

        write_default(REG_DEFAULT_YEAR, -9999);
        write_default(REG_DEFAULT_MONTH, 12);
        write_default(REG_DEFAULT_DAY, 31);
        run_random(47, 0, 55);

        write_default(REG_DEFAULT_YEAR, 9999);
        write_default(REG_DEFAULT_MONTH, 2);
        write_default(REG_DEFAULT_DAY, 29);
        run_random(0, 47, 55);

        // a zero default year makes every defaulted year load invalid
        write_default(REG_DEFAULT_YEAR, 0);
        write_default(REG_DEFAULT_MONTH, 1);
        write_default(REG_DEFAULT_DAY, 1);
        run_random(20, 20, 55);

        write_default(REG_DEFAULT_YEAR, -1);
        write_default(REG_DEFAULT_MONTH, 7);
        write_default(REG_DEFAULT_DAY, 30);
        run_random(0, 0, 50);

        $display("requests sent: %0d loads, %0d year adds, %0d month adds, %0d day adds",
                 op_count[OPC_LOAD], op_count[OPC_YEARS], op_count[OPC_MONTHS],
                 op_count[OPC_DAYS]);
        $display("%0d results over five default settings, %0d rejected, %0d saturated",
                 checked_count, rejected_count, saturated_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/cda_pkg.sv
rtl/cda_seq.sv
rtl/calendar_date_adder_core.sv
rtl/cda_checker.sv
test/calendar_date_adder_core_test.sv
